/* hdl/thwm_pkg.sv */
package thwm_pkg;

   localparam int RING_DEPTH = 32;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int STEP_W     = $clog2(RING_DEPTH + 1);

   localparam int TIME_W     = 64;
   localparam int DEV_W      = 8;
   localparam int CHAN_W     = 8;
   localparam int RKIND_W    = 2;
   localparam int EVENT_W    = 2;
   localparam int COUNT_W    = 6;

   localparam logic REQ_TRIGGER = 1'b0;
   localparam logic REQ_ACCEPT  = 1'b1;

   localparam logic [RKIND_W-1:0] RES_INSERT   = 2'd0;
   localparam logic [RKIND_W-1:0] RES_DECISION = 2'd1;
   localparam logic [RKIND_W-1:0] RES_SUMMARY  = 2'd2;
   localparam logic [RKIND_W-1:0] RES_EMPTY    = 2'd3;

   localparam logic [EVENT_W-1:0] EV_PLAIN     = 2'd0;
   localparam logic [EVENT_W-1:0] EV_FLUSH     = 2'd1;
   localparam logic [EVENT_W-1:0] EV_OVERWRITE = 2'd2;

   typedef struct packed {
      logic capture;
      logic trig_commit;
      logic eval_step;
      logic load_summary;
      logic load_error;
   } thwm_cmd_type;

   typedef struct packed {
      logic started;
      logic out_free;
      logic emit;
      logic walk_done;
   } thwm_status_type;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
      wrap_next = (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

endpackage

/* hdl/thwm_req_if.sv */
interface thwm_req_if import thwm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [TIME_W-1:0] trig_time;
   logic [DEV_W-1:0]  trig_device;
   logic [CHAN_W-1:0] channel;
   logic [TIME_W-1:0] window_start;
   logic [TIME_W-1:0] window_end;

   modport source (
      output valid, kind, trig_time, trig_device, channel, window_start, window_end,
      input  ready
   );

   modport sink (
      input  valid, kind, trig_time, trig_device, channel, window_start, window_end,
      output ready
   );
endinterface

/* hdl/thwm_rsp_if.sv */
interface thwm_rsp_if import thwm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RKIND_W-1:0] result_kind;
   logic [EVENT_W-1:0] insert_event;
   logic [DEV_W-1:0]   device_select;
   logic               decision;
   logic [TIME_W-1:0]  entry_stamp;
   logic [COUNT_W-1:0] accepted_count;
   logic               no_match;
   logic               last;

   modport source (
      output valid, result_kind, insert_event, device_select, decision, entry_stamp,
             accepted_count, no_match, last,
      input  ready
   );

   modport sink (
      input  valid, result_kind, insert_event, device_select, decision, entry_stamp,
             accepted_count, no_match, last,
      output ready
   );
endinterface

/* hdl/thwm_ctrl.sv */
module thwm_ctrl import thwm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_kind,
   output logic            req_ready,
   input  thwm_status_type status,
   output thwm_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TRIG = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_SUMM = 3'd3;
   localparam logic [2:0] ST_ERR  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE) && !reset;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               if (req_kind == REQ_TRIGGER) begin
                  state_in = ST_TRIG;
               end else if (status.started) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_TRIG: begin
            if (status.out_free) begin
               cmd.trig_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (status.out_free || !status.emit) begin
               cmd.eval_step = 1'b1;
               if (status.walk_done) begin
                  state_in = ST_SUMM;
               end
            end
         end
         ST_SUMM: begin
            if (status.out_free) begin
               cmd.load_summary = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.load_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/thwm_datapath.sv */
module thwm_datapath import thwm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  thwm_cmd_type       cmd,
   output thwm_status_type    status,
   input  logic [TIME_W-1:0]  req_trig_time,
   input  logic [DEV_W-1:0]   req_trig_device,
   input  logic [CHAN_W-1:0]  req_channel,
   input  logic [TIME_W-1:0]  req_window_start,
   input  logic [TIME_W-1:0]  req_window_end,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [RKIND_W-1:0] rsp_result_kind,
   output logic [EVENT_W-1:0] rsp_insert_event,
   output logic [DEV_W-1:0]   rsp_device_select,
   output logic               rsp_decision,
   output logic [TIME_W-1:0]  rsp_entry_stamp,
   output logic [COUNT_W-1:0] rsp_accepted_count,
   output logic               rsp_no_match,
   output logic               rsp_last
);

   logic [TIME_W-1:0] entry_time_ff    [RING_DEPTH];
   logic [DEV_W-1:0]  entry_device_ff  [RING_DEPTH];
   logic [CHAN_W-1:0] entry_channel_ff [RING_DEPTH];
   logic              entry_decided_ff [RING_DEPTH];

   logic [IDX_W-1:0]   head_ff;
   logic [IDX_W-1:0]   tail_ff;
   logic               started_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [STEP_W-1:0]  steps_ff;
   logic [COUNT_W-1:0] acc_ff;
   logic               any_ff;

   logic [TIME_W-1:0] time_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [TIME_W-1:0] wstart_ff;
   logic [TIME_W-1:0] wend_ff;

   logic [TIME_W-1:0] rd_time_ff;
   logic [DEV_W-1:0]  rd_dev_ff;
   logic [CHAN_W-1:0] rd_chan_ff;
   logic              rd_decided_ff;

   logic               out_valid_ff;
   logic [RKIND_W-1:0] out_kind_ff;
   logic [EVENT_W-1:0] out_event_ff;
   logic [DEV_W-1:0]   out_dev_ff;
   logic               out_dec_ff;
   logic [TIME_W-1:0]  out_stamp_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_nomatch_ff;
   logic               out_last_ff;

   logic [RKIND_W-1:0] out_kind_in;
   logic [EVENT_W-1:0] out_event_in;
   logic [DEV_W-1:0]   out_dev_in;
   logic               out_dec_in;
   logic [TIME_W-1:0]  out_stamp_in;
   logic [COUNT_W-1:0] out_count_in;
   logic               out_nomatch_in;
   logic               out_last_in;
   logic               out_load;

   logic [IDX_W-1:0] idx_next;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] span;
   logic             in_win;
   logic             older;
   logic             hit;
   logic             match;
   logic             emit;
   logic             full;
   logic             adv_head;

   assign idx_next = wrap_next(idx_ff);
   assign rd_addr  = cmd.capture ? head_ff : (cmd.eval_step ? idx_next : idx_ff);

   assign in_win = (rd_time_ff >= wstart_ff) && (rd_time_ff <= wend_ff);
   assign older  = (rd_time_ff < wstart_ff);
   assign hit    = in_win || older;
   assign match  = in_win && (rd_chan_ff == chan_ff);
   assign emit   = hit && !rd_decided_ff;
   assign full   = started_ff && (tail_ff == head_ff);

   assign span = (tail_ff >= head_ff) ? IDX_W'(tail_ff - head_ff)
                                      : IDX_W'(RING_DEPTH - 32'(head_ff) + 32'(tail_ff));
   assign adv_head = hit && (idx_ff == head_ff) && (span > IDX_W'(1));

   assign status.started   = started_ff;
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.emit      = emit;
   assign status.walk_done = (idx_next == tail_ff) || (steps_ff == STEP_W'(RING_DEPTH - 1));

   always_comb begin
      out_load       = 1'b1;
      out_kind_in    = RES_INSERT;
      out_event_in   = EV_PLAIN;
      out_dev_in     = '0;
      out_dec_in     = 1'b0;
      out_stamp_in   = '0;
      out_count_in   = '0;
      out_nomatch_in = 1'b0;
      out_last_in    = 1'b1;
      if (cmd.trig_commit) begin
         if (full) begin
            out_event_in = rd_decided_ff ? EV_FLUSH : EV_OVERWRITE;
         end
      end else if (cmd.eval_step && emit) begin
         out_kind_in  = RES_DECISION;
         out_dev_in   = rd_dev_ff;
         out_dec_in   = match;
         out_stamp_in = rd_time_ff;
         out_last_in  = 1'b0;
      end else if (cmd.load_summary) begin
         out_kind_in    = RES_SUMMARY;
         out_count_in   = acc_ff;
         out_nomatch_in = !any_ff;
      end else if (cmd.load_error) begin
         out_kind_in = RES_EMPTY;
      end else begin
         out_load = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         started_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.trig_commit) begin
            if (!started_ff) begin
               started_ff <= 1'b1;
               head_ff    <= '0;
            end else if (full) begin
               head_ff <= wrap_next(head_ff);
            end
            tail_ff <= wrap_next(tail_ff);
         end else if (cmd.eval_step && adv_head) begin
            head_ff <= wrap_next(head_ff);
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff   <= req_trig_time;
         dev_ff    <= req_trig_device;
         chan_ff   <= req_channel;
         wstart_ff <= req_window_start;
         wend_ff   <= req_window_end;
         idx_ff    <= head_ff;
         steps_ff  <= '0;
         acc_ff    <= '0;
         any_ff    <= 1'b0;
      end else if (cmd.eval_step) begin
         idx_ff   <= idx_next;
         steps_ff <= steps_ff + 1'b1;
         if (emit && match) begin
            acc_ff <= acc_ff + 1'b1;
         end
         if (hit) begin
            any_ff <= 1'b1;
         end
      end
      if (out_load) begin
         out_kind_ff    <= out_kind_in;
         out_event_ff   <= out_event_in;
         out_dev_ff     <= out_dev_in;
         out_dec_ff     <= out_dec_in;
         out_stamp_ff   <= out_stamp_in;
         out_count_ff   <= out_count_in;
         out_nomatch_ff <= out_nomatch_in;
         out_last_ff    <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trig_commit) begin
         entry_time_ff[tail_ff]    <= time_ff;
         entry_device_ff[tail_ff]  <= dev_ff;
         entry_channel_ff[tail_ff] <= chan_ff;
      end
      rd_time_ff <= entry_time_ff[rd_addr];
      rd_dev_ff  <= entry_device_ff[rd_addr];
      rd_chan_ff <= entry_channel_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.trig_commit) begin
         entry_decided_ff[tail_ff] <= 1'b0;
      end else if (cmd.eval_step && emit) begin
         entry_decided_ff[idx_ff] <= 1'b1;
      end
      rd_decided_ff <= entry_decided_ff[rd_addr];
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_insert_event   = out_event_ff;
   assign rsp_device_select  = out_dev_ff;
   assign rsp_decision       = out_dec_ff;
   assign rsp_entry_stamp    = out_stamp_ff;
   assign rsp_accepted_count = out_count_ff;
   assign rsp_no_match       = out_nomatch_ff;
   assign rsp_last           = out_last_ff;

endmodule

/* hdl/trigger_hold_window_matcher_core.sv */
// Holds up to RING_DEPTH pending triggers in a ring and settles them against accept
// windows. A trigger item yields one insert report. An accept item is loaded, then
// walks the ring entries from head to tail (up to RING_DEPTH), then gives a summary;
// the pace of the walk is set by the single registered read port of the entry
// memories. An accept before any trigger has been inserted gives one error result.
// While a result cannot be handed over because the previous one is still waiting,
// the block holds and waits for the result register to be free.
module trigger_hold_window_matcher_core import thwm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   thwm_req_if.sink          req_bus,
   thwm_rsp_if.source        rsp_bus
);

   thwm_cmd_type    cmd;
   thwm_status_type status;

   thwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   thwm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_trig_time      (req_bus.trig_time),
      .req_trig_device    (req_bus.trig_device),
      .req_channel        (req_bus.channel),
      .req_window_start   (req_bus.window_start),
      .req_window_end     (req_bus.window_end),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_result_kind    (rsp_bus.result_kind),
      .rsp_insert_event   (rsp_bus.insert_event),
      .rsp_device_select  (rsp_bus.device_select),
      .rsp_decision       (rsp_bus.decision),
      .rsp_entry_stamp    (rsp_bus.entry_stamp),
      .rsp_accepted_count (rsp_bus.accepted_count),
      .rsp_no_match       (rsp_bus.no_match),
      .rsp_last           (rsp_bus.last)
   );

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.trig_commit, cmd.eval_step, cmd.load_summary,
                cmd.load_error}))
      else $error("More than one datapath command in one cycle.");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.trig_commit || cmd.load_summary || cmd.load_error ||
       (cmd.eval_step && status.emit)) |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("Result register loaded while still holding an item.");

   a_started_after_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.trig_commit |=> status.started)
      else $error("Ring not marked as started after a trigger insert.");

endmodule
